>>> rtl/bounded_stack_bank_core_assert.svh
// Assertion macros shared by the stack bank RTL.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef BOUNDED_STACK_BANK_CORE_ASSERT_SVH
`define BOUNDED_STACK_BANK_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stack bank assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack bank assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/bsb_pkg.sv
// Shared constants, codes and structs of the stack bank.
// No dependencies; bsb_flags and the stack bank top import it.
package bsb_pkg;

   localparam int NUM_STACKS = 64;
   localparam int MAX_DEPTH  = 16;
   localparam int STACK_W    = $clog2(NUM_STACKS);
   localparam int DEPTH_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
   localparam int PLATE_W    = 32;
   localparam int CAP_W      = 5;
   localparam int PLATE_AW   = STACK_W + DEPTH_W;
   localparam int PLATE_DEPTH = NUM_STACKS * (1 << DEPTH_W);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_POP_AT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic               found;
      logic [STACK_W-1:0] stack;
   } pick_type;

   typedef struct packed {
      logic               en;
      logic [STACK_W-1:0] stack;
      logic               nonempty;
      logic               full;
   } flag_upd_type;

   // Clamp the capacity register into 1..MAX_DEPTH.
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] res;
      if (cap == '0) begin
         res = CNT_W'(1);
      end else if ({1'b0, cap} > (CAP_W+1)'(MAX_DEPTH)) begin
         res = CNT_W'(MAX_DEPTH);
      end else begin
         res = CNT_W'(cap);
      end
      return res;
   endfunction

endpackage

>>> rtl/bsb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the plate store and the fill counts.
module bsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bsb_flags.sv
// Per-stack non-empty and full flags with the priority encoders that pick a stack.
// Depends on bsb_pkg and the assertion macro header.
`include "bounded_stack_bank_core_assert.svh"

module bsb_flags
   import bsb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  flag_upd_type       upd,
   input  logic [1:0]         op,
   input  logic [STACK_W-1:0] idx,
   output pick_type           pick,
   output logic [NUM_STACKS-1:0] nonempty_vec
);

   logic [NUM_STACKS-1:0] nonempty_ff;
   logic [NUM_STACKS-1:0] full_ff;
   logic [STACK_W-1:0]    low_open;
   logic [STACK_W-1:0]    high_used;

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         full_ff     <= '0;
      end else if (upd.en) begin
         nonempty_ff[upd.stack] <= upd.nonempty;
         full_ff[upd.stack]     <= upd.full;
      end
   end

   // lowest stack with room, highest stack holding a plate
   always_comb begin
      low_open  = '0;
      high_used = '0;
      for (int i = NUM_STACKS - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            low_open = STACK_W'(i);
         end
      end
      for (int i = 0; i < NUM_STACKS; i++) begin
         if (nonempty_ff[i]) begin
            high_used = STACK_W'(i);
         end
      end
   end

   always_comb begin
      case (op)
         OP_PUSH: begin
            pick.found = !(&full_ff);
            pick.stack = (&full_ff) ? '0 : low_open;
         end
         OP_POP: begin
            pick.found = |nonempty_ff;
            pick.stack = high_used;
         end
         OP_POP_AT: begin
            pick.found = nonempty_ff[idx];
            pick.stack = idx;
         end
         default: begin
            pick.found = 1'b0;
            pick.stack = '0;
         end
      endcase
   end

   assign nonempty_vec = nonempty_ff;

   `ASSERT_IMPLIES(a_full_has_plates, clock, reset, 1'b1, (full_ff & ~nonempty_ff) == '0)
   `ASSERT_IMPLIES(a_push_pick_open, clock, reset, (op == OP_PUSH) && pick.found, !full_ff[pick.stack])
   `ASSERT_NEXT(a_upd_lands, clock, reset, upd.en, nonempty_ff[$past(upd.stack)] == $past(upd.nonempty))

endmodule

>>> rtl/bounded_stack_bank_core.sv
// Stack bank top: a push result is registered after the fill-count RAM read, a pop
// result after that read and then the plate RAM read. Requests are taken only when
// idle; a held response stalls the count and plate states until rsp_tready is high.
// Reset is synchronous: fill flags clear at once, capacity returns to 8, no clearing pass.
// A capacity write triggers a flag refresh over every count RAM entry, with req_tready low
// meanwhile. Depends on bsb_pkg, bsb_ram, bsb_flags and the assertion macro header.
`include "bounded_stack_bank_core_assert.svh"

module bounded_stack_bank_core
   import bsb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,   // value[31:0], index[37:32], zero fill
   input  logic [1:0]       req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,   // popped[31:0], stack_used[37:32], zero fill
   output logic [1:0]       rsp_tuser,   // status[1:0]
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data  // capacity
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COUNT,
      S_PLATE,
      S_SWEEP
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [PLATE_W-1:0]  value_ff, value_in;
   logic [STACK_W-1:0]  stack_ff, stack_in;
   logic                hit_ff, hit_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic                sweep_req_ff, sweep_req_in;
   logic [STACK_W:0]    sweep_ptr_ff, sweep_ptr_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [STACK_W-1:0]  chk_idx_ff, chk_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PLATE_W-1:0]  rsp_popped_ff, rsp_popped_in;
   logic [STACK_W-1:0]  rsp_stack_ff, rsp_stack_in;
   status_type          rsp_status_ff, rsp_status_in;

   pick_type              pick;
   flag_upd_type          upd;
   logic [NUM_STACKS-1:0] nonempty_vec;

   logic                cnt_we, cnt_re;
   logic [STACK_W-1:0]  cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
   logic                plate_we, plate_re;
   logic [PLATE_AW-1:0] plate_waddr, plate_raddr;
   logic [PLATE_W-1:0]  plate_rdata;

   logic                accept, out_free;
   logic [CNT_W-1:0]    ecap, cnt_cur, cnt_up, cnt_down;
   logic [STACK_W-1:0]  cur_idx;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ecap     = eff_cap(cap_ff);
   assign cur_idx  = (state_ff == S_SWEEP) ? chk_idx_ff : stack_ff;
   // a stack without plates reads as count zero, whatever the RAM holds
   assign cnt_cur  = nonempty_vec[cur_idx] ? cnt_rdata : '0;
   assign cnt_up   = cnt_cur + CNT_W'(1);
   assign cnt_down = cnt_cur - CNT_W'(1);

   bsb_flags u_flags (
      .clock        (clock),
      .reset        (reset),
      .upd          (upd),
      .op           (req_tuser),
      .idx          (req_tdata[37:32]),
      .pick         (pick),
      .nonempty_vec (nonempty_vec)
   );

   bsb_ram #(.WIDTH(CNT_W), .DEPTH(NUM_STACKS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   bsb_ram #(.WIDTH(PLATE_W), .DEPTH(PLATE_DEPTH)) u_plate_ram (
      .clock   (clock),
      .wr_en   (plate_we),
      .wr_addr (plate_waddr),
      .wr_data (value_ff),
      .rd_en   (plate_re),
      .rd_addr (plate_raddr),
      .rd_data (plate_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      stack_in      = stack_ff;
      hit_in        = hit_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      sweep_req_in  = sweep_req_ff || csr_wr_en;
      sweep_ptr_in  = sweep_ptr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_popped_in = rsp_popped_ff;
      rsp_stack_in  = rsp_stack_ff;
      rsp_status_in = rsp_status_ff;

      upd          = '0;
      cnt_we       = 1'b0;
      cnt_waddr    = stack_ff;
      cnt_wdata    = cnt_up;
      cnt_re       = 1'b0;
      cnt_raddr    = pick.stack;
      plate_we     = 1'b0;
      plate_waddr  = {stack_ff, DEPTH_W'(cnt_cur)};
      plate_re     = 1'b0;
      plate_raddr  = {stack_ff, DEPTH_W'(cnt_down)};

      case (state_ff)
         S_IDLE: begin
            if (sweep_req_ff) begin
               sweep_req_in = csr_wr_en;
               sweep_ptr_in = '0;
               state_in     = S_SWEEP;
            end else if (accept) begin
               op_in    = req_tuser;
               value_in = req_tdata[31:0];
               stack_in = pick.stack;
               hit_in   = pick.found;
               cnt_re   = 1'b1;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            if (out_free) begin
               upd.stack = stack_ff;
               if (hit_ff && (op_ff == OP_PUSH)) begin
                  cnt_we        = 1'b1;
                  plate_we      = 1'b1;
                  upd.en        = 1'b1;
                  upd.nonempty  = 1'b1;
                  upd.full      = (cnt_up >= ecap);
                  rsp_valid_in  = 1'b1;
                  rsp_popped_in = '0;
                  rsp_stack_in  = stack_ff;
                  rsp_status_in = ST_OK;
                  state_in      = S_IDLE;
               end else if (hit_ff) begin
                  cnt_we       = 1'b1;
                  cnt_wdata    = cnt_down;
                  plate_re     = 1'b1;
                  upd.en       = 1'b1;
                  upd.nonempty = (cnt_down != '0);
                  upd.full     = (cnt_down != '0) && (cnt_down >= ecap);
                  state_in     = S_PLATE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_popped_in = '0;
                  rsp_stack_in  = stack_ff;
                  rsp_status_in = (op_ff == OP_PUSH) ? ST_FULL : ST_EMPTY;
                  state_in      = S_IDLE;
               end
            end
         end
         S_PLATE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = plate_rdata;
               rsp_stack_in  = stack_ff;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         S_SWEEP: begin
            // read one count per cycle, refresh its full flag the cycle after
            if (sweep_ptr_ff < (STACK_W+1)'(NUM_STACKS)) begin
               cnt_re       = 1'b1;
               cnt_raddr    = sweep_ptr_ff[STACK_W-1:0];
               chk_vld_in   = 1'b1;
               chk_idx_in   = sweep_ptr_ff[STACK_W-1:0];
               sweep_ptr_in = sweep_ptr_ff + (STACK_W+1)'(1);
            end else begin
               state_in = S_IDLE;
            end
            if (chk_vld_ff) begin
               upd.en       = 1'b1;
               upd.stack    = chk_idx_ff;
               upd.nonempty = nonempty_vec[chk_idx_ff];
               upd.full     = nonempty_vec[chk_idx_ff] && (cnt_cur >= ecap);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         sweep_req_ff <= 1'b0;
         sweep_ptr_ff <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         sweep_req_ff <= sweep_req_in;
         sweep_ptr_ff <= sweep_ptr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      stack_ff      <= stack_in;
      hit_ff        <= hit_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_stack_ff  <= rsp_stack_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !sweep_req_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_stack_ff, rsp_popped_ff};
   assign rsp_tuser  = rsp_status_ff;

   `ASSERT_NEXT(a_accept_to_count, clock, reset, accept, state_ff == S_COUNT)
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
                   ($past(state_ff) == S_COUNT) || ($past(state_ff) == S_PLATE))
   `ASSERT_IMPLIES(a_plate_after_hit, clock, reset, state_ff == S_PLATE,
                   hit_ff && (op_ff != OP_PUSH))

endmodule
